/* sv/rfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and the byte-wide CRC-16 update for the frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

	localparam int          MAX_FRAME_DEF = 255;

	localparam logic [7:0]  MAGIC_BYTE    = 8'hA5;
	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [15:0] CRC_SEED      = 16'hFFFF;
	localparam logic [8:0]  COUNT_TOP     = 9'd511;
	localparam logic [8:0]  MIN_FRAME     = 9'd11;
	localparam logic [9:0]  HDR_PLUS_CRC  = 10'd11;

	localparam int          FLAG_ENC_BIT  = 0;
	localparam int          FLAG_SOS_BIT  = 1;
	localparam int          FLAG_POS_BIT  = 2;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_SHORT        = 3'd1,
		ST_BAD_MAGIC    = 3'd2,
		ST_BAD_CRC      = 3'd3,
		ST_LEN_MISMATCH = 3'd4,
		ST_OWN_FRAME    = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rx_item_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  flags;
		logic [7:0]  msg_type;
		logic [7:0]  seq;
		logic [31:0] source;
		logic [7:0]  payload_len;
	} frame_res_t;

	// msb-first crc-16, one byte, eight shift steps
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* sv/rfc_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_in_reg
// Input register for received bytes; holds one request until the core takes it.
// ----------------------------------------------------------------------------
module rfc_in_reg
	import rfc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rx_valid,
	output logic     rx_ready,
	input  rx_item_t rx_item,
	input  logic     take,
	output logic     valid_s1,
	output rx_item_t item_s1
);

	assign rx_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			item_s1 <= rx_item;
		end
	end

endmodule

/* sv/rfc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_core
// Per-frame tracking (crc, trailer delay, count, header capture) and the
// registered result produced on the last byte.
// ----------------------------------------------------------------------------
module rfc_core
	import rfc_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  rx_item_t    item_s1,
	input  logic [31:0] own_id,
	output logic        take,
	output logic        res_valid_q,
	input  logic        res_ready,
	output frame_res_t  res_q
);

	localparam logic [8:0] MaxFrameC = 9'(MAX_FRAME);

	logic [15:0] crc_q;
	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic [8:0]  count_q;
	logic        magic_q;
	logic [7:0]  flags_q;
	logic [7:0]  type_q;
	logic [7:0]  seq_q;
	logic [31:0] source_q;
	logic [7:0]  payload_len_q;

	logic [15:0] crc_nx;
	logic        magic_nx;
	logic [7:0]  flags_nx;
	logic [7:0]  type_nx;
	logic [7:0]  seq_nx;
	logic [31:0] source_nx;
	logic [7:0]  payload_len_nx;
	logic [8:0]  count_nx;
	logic [15:0] got_crc;
	logic [9:0]  expect_len;
	status_t     status_nx;

	// a non-last byte never waits on the result side
	assign take = valid_s1 && (!item_s1.last || !res_valid_q || res_ready);

	always_comb begin
		crc_nx         = (count_q[8:1] != 8'd0) ? crc_feed(crc_q, held0_q) : crc_q;
		magic_nx       = magic_q;
		flags_nx       = flags_q;
		type_nx        = type_q;
		seq_nx         = seq_q;
		source_nx      = source_q;
		payload_len_nx = payload_len_q;
		if (count_q == 9'd0) begin
			magic_nx = (item_s1.data == MAGIC_BYTE);
		end
		if (count_q == 9'd1) begin
			flags_nx = item_s1.data;
		end
		if (count_q == 9'd2) begin
			type_nx = item_s1.data;
		end
		if (count_q == 9'd3) begin
			seq_nx = item_s1.data;
		end
		// offsets 4..7, little endian
		if (count_q[8:2] == 7'd1) begin
			source_nx[{count_q[1:0], 3'b000} +: 8] =
				source_q[{count_q[1:0], 3'b000} +: 8] | item_s1.data;
		end
		if (count_q == 9'd8) begin
			payload_len_nx = item_s1.data;
		end
		count_nx   = (count_q != COUNT_TOP) ? count_q + 9'd1 : count_q;
		got_crc    = {item_s1.data, held1_q};
		expect_len = HDR_PLUS_CRC + {2'b00, payload_len_nx};

		if (count_nx < MIN_FRAME) begin
			status_nx = ST_SHORT;
		end else if (!magic_nx) begin
			status_nx = ST_BAD_MAGIC;
		end else if (crc_nx != got_crc) begin
			status_nx = ST_BAD_CRC;
		end else if (count_nx > MaxFrameC || {1'b0, count_nx} != expect_len) begin
			status_nx = ST_LEN_MISMATCH;
		end else if (source_nx == own_id) begin
			status_nx = ST_OWN_FRAME;
		end else begin
			status_nx = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q         <= CRC_SEED;
			held0_q       <= 8'd0;
			held1_q       <= 8'd0;
			count_q       <= 9'd0;
			magic_q       <= 1'b0;
			flags_q       <= 8'd0;
			type_q        <= 8'd0;
			seq_q         <= 8'd0;
			source_q      <= 32'd0;
			payload_len_q <= 8'd0;
		end else if (take) begin
			if (item_s1.last) begin
				crc_q         <= CRC_SEED;
				held0_q       <= 8'd0;
				held1_q       <= 8'd0;
				count_q       <= 9'd0;
				magic_q       <= 1'b0;
				flags_q       <= 8'd0;
				type_q        <= 8'd0;
				seq_q         <= 8'd0;
				source_q      <= 32'd0;
				payload_len_q <= 8'd0;
			end else begin
				crc_q         <= crc_nx;
				held0_q       <= held1_q;
				held1_q       <= item_s1.data;
				count_q       <= count_nx;
				magic_q       <= magic_nx;
				flags_q       <= flags_nx;
				type_q        <= type_nx;
				seq_q         <= seq_nx;
				source_q      <= source_nx;
				payload_len_q <= payload_len_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && item_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last) begin
			res_q.status      <= status_nx;
			res_q.flags       <= flags_nx;
			res_q.msg_type    <= type_nx;
			res_q.seq         <= seq_nx;
			res_q.source      <= source_nx;
			res_q.payload_len <= payload_len_nx;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && item_s1.last |=> count_q == 9'd0 && crc_q == CRC_SEED)
		else $error("frame state not cleared after last byte");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !item_s1.last && count_q != COUNT_TOP |=> count_q == $past(count_q) + 9'd1)
		else $error("byte count did not advance");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && item_s1.last |=> res_valid_q)
		else $error("last byte produced no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |-> !(take && item_s1.last))
		else $error("pending result overwritten");

endmodule

/* sv/radio_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_frame_checker
// CRC-16 and header check of a received frame, one byte per request.
//
//   channel  dir  handshake                 payload
//   rx       in   rx_valid / rx_ready       rx_byte, frame_end
//   res      out  res_valid / res_ready     status, header fields, flag bits
//   cfg      in   cfg_wr_en                 cfg_wr_data (own id)
//
// One byte per cycle sustained unless a last byte waits on a pending result:
// the byte-wide crc update is done in one pass between the input register
// and the frame state registers. Taking a last byte registers its result.
// Reset loads the crc with all ones and clears count, header and own id.
// A stall on res_ready holds only a last byte in the input register; other
// bytes keep flowing while a result waits.
// ----------------------------------------------------------------------------
module radio_frame_checker
	import rfc_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  status,
	output logic [7:0]  frame_flags,
	output logic [7:0]  msg_type,
	output logic [7:0]  seq_num,
	output logic [31:0] source_id,
	output logic [7:0]  body_length,
	output logic        is_encrypted,
	output logic        is_sos,
	output logic        has_position
);

	logic        own_id_q;
	logic [31:0] own_id_val_q;
	rx_item_t    rx_item;
	rx_item_t    item_s1;
	logic        valid_s1;
	logic        take;
	frame_res_t  res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_val_q <= 32'd0;
			own_id_q     <= 1'b0;
		end else if (cfg_wr_en) begin
			own_id_val_q <= cfg_wr_data;
			own_id_q     <= 1'b1;
		end
	end

	assign rx_item.data = rx_byte;
	assign rx_item.last = frame_end;

	rfc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_item  (rx_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rfc_core #(
		.MAX_FRAME (MAX_FRAME)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.own_id      (own_id_q ? own_id_val_q : 32'd0),
		.take        (take),
		.res_valid_q (res_valid),
		.res_ready   (res_ready),
		.res_q       (res_q)
	);

	assign status       = res_q.status;
	assign frame_flags  = res_q.flags;
	assign msg_type     = res_q.msg_type;
	assign seq_num      = res_q.seq;
	assign source_id    = res_q.source;
	assign body_length  = res_q.payload_len;
	assign is_encrypted = res_q.flags[FLAG_ENC_BIT];
	assign is_sos       = res_q.flags[FLAG_SOS_BIT];
	assign has_position = res_q.flags[FLAG_POS_BIT];

endmodule
